FILE: rtl/imucfp_pkg.sv
// ----------------------------------------------------------------------------
// imucfp_pkg
// Shared types and constants of the checksum frame parser.
// ----------------------------------------------------------------------------
package imucfp_pkg;

  localparam int unsigned FrameLen   = 11;
  localparam int unsigned WinDepth   = FrameLen - 1;
  localparam int unsigned FillW      = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] FrameHeader = 8'h55;
  localparam logic [7:0] TypeAccel   = 8'h51;
  localparam logic [7:0] TypeRate    = 8'h52;
  localparam logic [7:0] TypeQuat    = 8'h59;

  typedef enum logic [1:0] {
    KindAccel = 2'd0,
    KindRate  = 2'd1,
    KindQuat  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]          packet_kind;
    logic signed [15:0]  value_a;
    logic signed [15:0]  value_b;
    logic signed [15:0]  value_c;
    logic signed [15:0]  value_d;
    logic                record_complete;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } head_t;

endpackage

FILE: rtl/imucfp_if.sv
// ----------------------------------------------------------------------------
// imucfp_byte_if / imucfp_result_if
// Valid/ready channels for received bytes and decoded frame results.
// ----------------------------------------------------------------------------
interface imucfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface imucfp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         packet_kind;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;
  logic signed [15:0] value_c;
  logic signed [15:0] value_d;
  logic               record_complete;

  modport source (output valid, output packet_kind, output value_a, output value_b,
                  output value_c, output value_d, output record_complete, input ready);
  modport sink (input valid, input packet_kind, input value_a, input value_b,
                input value_c, input value_d, input record_complete, output ready);
endinterface

FILE: rtl/imucfp_front.sv
// ----------------------------------------------------------------------------
// imucfp_front
// Byte window with fill count, header and checksum check, frame decode.
// ----------------------------------------------------------------------------
module imucfp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  input  logic                 queue_full_i,
  output logic                 byte_ready_o,
  output imucfp_pkg::push_t    push_o
);

  logic [7:0] win_q [imucfp_pkg::WinDepth];
  logic [7:0] win_d [imucfp_pkg::WinDepth];
  logic [imucfp_pkg::FillW-1:0] fill_q, fill_d;
  logic [7:0] cand [imucfp_pkg::FrameLen];
  logic [7:0] sum;
  logic       accept;
  logic       full;
  logic       is_frame;
  logic       known;
  logic       quat;
  logic [1:0] kind;

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign full         = fill_q >= imucfp_pkg::FillW'(imucfp_pkg::WinDepth);

  always_comb begin
    for (int i = 0; i < imucfp_pkg::WinDepth; i++) begin
      cand[i] = win_q[i];
    end
    cand[imucfp_pkg::FrameLen-1] = byte_i;
    sum = '0;
    for (int i = 0; i < imucfp_pkg::WinDepth; i++) begin
      sum = sum + cand[i];
    end
    is_frame = (cand[0] == imucfp_pkg::FrameHeader) &&
               (sum == cand[imucfp_pkg::FrameLen-1]);
  end

  always_comb begin
    known = 1'b1;
    kind  = imucfp_pkg::KindAccel;
    unique case (cand[1])
      imucfp_pkg::TypeAccel: kind = imucfp_pkg::KindAccel;
      imucfp_pkg::TypeRate:  kind = imucfp_pkg::KindRate;
      imucfp_pkg::TypeQuat:  kind = imucfp_pkg::KindQuat;
      default:               known = 1'b0;
    endcase
    quat = (kind == imucfp_pkg::KindQuat);
  end

  always_comb begin
    push_o.valid                = accept && full && is_frame && known;
    push_o.data.packet_kind     = kind;
    push_o.data.value_a         = {cand[3], cand[2]};
    push_o.data.value_b         = {cand[5], cand[4]};
    push_o.data.value_c         = {cand[7], cand[6]};
    push_o.data.value_d         = quat ? {cand[9], cand[8]} : 16'sd0;
    push_o.data.record_complete = quat;
  end

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (accept) begin
      if (!full) begin
        for (int i = 0; i < imucfp_pkg::WinDepth; i++) begin
          if (fill_q == imucfp_pkg::FillW'(i)) win_d[i] = byte_i;
        end
        fill_d = fill_q + 1'b1;
      end else if (is_frame) begin
        fill_d = '0;
      end else begin
        for (int i = 0; i < imucfp_pkg::WinDepth; i++) begin
          win_d[i] = cand[i+1];
        end
        fill_d = imucfp_pkg::FillW'(imucfp_pkg::WinDepth);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= imucfp_pkg::FillW'(imucfp_pkg::WinDepth))
    else $error("window fill count out of range");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |=> fill_q == '0)
    else $error("window not emptied after a frame");

endmodule

FILE: rtl/imucfp_queue.sv
// ----------------------------------------------------------------------------
// imucfp_queue
// Short result queue between frame decode and the output stage.
// ----------------------------------------------------------------------------
module imucfp_queue #(
  parameter int unsigned Depth = imucfp_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imucfp_pkg::push_t  push_i,
  input  logic               pop_i,
  output logic               full_o,
  output imucfp_pkg::head_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  imucfp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = cnt_q == CntW'(Depth);
  assign head_o.valid = cnt_q != '0;
  assign head_o.data  = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.data;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("result pushed into a full queue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

FILE: rtl/imucfp_out.sv
// ----------------------------------------------------------------------------
// imucfp_out
// Output register that drains the result queue onto the result channel.
// ----------------------------------------------------------------------------
module imucfp_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imucfp_pkg::head_t  head_i,
  output logic               pop_o,
  imucfp_result_if.source    res_o
);

  logic                valid_q;
  imucfp_pkg::result_t data_q;

  assign pop_o = head_i.valid && (!valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || res_o.ready) begin
      valid_q <= head_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i.data;
  end

  assign res_o.valid           = valid_q;
  assign res_o.packet_kind     = data_q.packet_kind;
  assign res_o.value_a         = data_q.value_a;
  assign res_o.value_b         = data_q.value_b;
  assign res_o.value_c         = data_q.value_c;
  assign res_o.value_d         = data_q.value_d;
  assign res_o.record_complete = data_q.record_complete;

endmodule

FILE: rtl/imu_checksum_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_checksum_frame_parser
// Resynchronizing parser for 11-byte sensor frames with header and checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle. Bytes fill a ten-byte window; with
// the eleventh byte the window is checked for the 0x55 header and the 8-bit
// additive checksum in the same cycle. A good frame empties the window, a bad
// one drops its oldest byte. Acceleration, angular rate and quaternion frames
// give one result item with the raw little-endian words; the result passes
// through the queue and then the output register before it is valid on the
// output. Results wait in a QueueDepth-entry queue plus one output register.
// The byte input stalls while the queue is full, which happens only when the
// output register and every queue entry hold results that the sink has not
// yet taken.
// ----------------------------------------------------------------------------
module imu_checksum_frame_parser #(
  parameter int unsigned QueueDepth = imucfp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  imucfp_byte_if.sink      rx_i,
  imucfp_result_if.source  res_o
);

  imucfp_pkg::push_t push;
  imucfp_pkg::head_t head;
  logic              queue_full;
  logic              pop;

  imucfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (rx_i.valid),
    .byte_i       (rx_i.rx_byte),
    .queue_full_i (queue_full),
    .byte_ready_o (rx_i.ready),
    .push_o       (push)
  );

  imucfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (queue_full),
    .head_o (head)
  );

  imucfp_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule
